>>> hdl/rlf_pkg.sv
package rlf_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;
  localparam int CNT_W       = 9;

  localparam logic [7:0] RESP_TIMEOUT_RST  = 8'd3;
  localparam logic [7:0] STARTUP_GRACE_RST = 8'd3;

  // flag bit positions within a port status
  localparam int FLG_OPENED = 0;
  localparam int FLG_ACTIVE = 1;
  localparam int FLG_NODATA = 2;
  localparam int FLG_BAD    = 3;

  typedef enum logic [1:0] {
    REQ_CONNECT    = 2'd0,
    REQ_DISCONNECT = 2'd1,
    REQ_DATA       = 2'd2,
    REQ_TICK       = 2'd3
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUERY_EN      = 3'd0,
    CFG_SEPARATE      = 3'd1,
    CFG_SINGLE        = 3'd2,
    CFG_RESP_TIMEOUT  = 3'd3,
    CFG_STARTUP_GRACE = 3'd4
  } cfg_idx_t;

  typedef logic [3:0]              flags_t;
  typedef logic signed [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic       query_en;
    logic       separate;
    logic       single;
    logic [7:0] resp_timeout;
    logic [7:0] grace;
  } cfg_t;

  typedef struct packed {
    logic      bad_data;
    logic      port;
    req_type_t req_type;
  } req_t;

  // main_status sits in the low bits
  typedef struct packed {
    logic   probe_reserve;
    logic   probe_main;
    logic   all_disconnected;
    logic   first_connected;
    logic   state_changed;
    flags_t reserve_status;
    flags_t main_status;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

>>> hdl/rlf_cfg_regs.sv
module rlf_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rlf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rlf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output rlf_pkg::cfg_t                   cfg
);
  import rlf_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_QUERY_EN:      cfg_nxt.query_en     = cfg_wdata[0];
        CFG_SEPARATE:      cfg_nxt.separate     = cfg_wdata[0];
        CFG_SINGLE:        cfg_nxt.single       = cfg_wdata[0];
        CFG_RESP_TIMEOUT:  cfg_nxt.resp_timeout = cfg_wdata[7:0];
        CFG_STARTUP_GRACE: cfg_nxt.grace        = cfg_wdata[7:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_en     <= 1'b0;
      cfg_r.separate     <= 1'b0;
      cfg_r.single       <= 1'b0;
      cfg_r.resp_timeout <= RESP_TIMEOUT_RST;
      cfg_r.grace        <= STARTUP_GRACE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/rlf_step.sv
module rlf_step (
  input  rlf_pkg::cfg_t   cfg,
  input  rlf_pkg::req_t   req,
  input  rlf_pkg::flags_t flags_i [2],
  input  rlf_pkg::cnt_t   cnt_i   [2],
  output rlf_pkg::flags_t flags_o [2],
  output rlf_pkg::cnt_t   cnt_o   [2],
  output rlf_pkg::res_t   res
);
  import rlf_pkg::*;

  flags_t fl [2];
  cnt_t   cn [2];
  cnt_t   grace_neg;
  cnt_t   resp_pos;
  logic   p, q;
  logic   need;
  logic   swapped;

  assign grace_neg = cnt_t'(9'd0 - {1'b0, cfg.grace});
  assign resp_pos  = cnt_t'({1'b0, cfg.resp_timeout});
  assign p = req.port;
  assign q = ~req.port;

  always_comb begin
    fl      = flags_i;
    cn      = cnt_i;
    res     = '0;
    need    = 1'b0;
    swapped = 1'b0;
    case (req.req_type)
      REQ_CONNECT: begin
        if (!fl[p][FLG_OPENED]) begin
          res.first_connected = !fl[q][FLG_OPENED];
          if (cfg.separate || !fl[q][FLG_OPENED]) fl[p][FLG_ACTIVE] = 1'b1;
          fl[p][FLG_OPENED] = 1'b1;
          cn[p] = grace_neg;
          res.state_changed = 1'b1;
        end
      end
      REQ_DISCONNECT: begin
        if (fl[p][FLG_OPENED]) begin
          res.all_disconnected = !fl[q][FLG_OPENED];
          cn[p] = '0;
          fl[p][FLG_NODATA] = 1'b0;
          fl[p][FLG_OPENED] = 1'b0;
          fl[p][FLG_ACTIVE] = 1'b0;
          if (!cfg.separate && fl[q][FLG_OPENED] && !fl[q][FLG_ACTIVE])
            fl[q][FLG_ACTIVE] = 1'b1;
          res.state_changed = 1'b1;
        end
      end
      REQ_DATA: begin
        if (fl[p][FLG_OPENED]) begin
          fl[p][FLG_BAD] = req.bad_data;
          // counter not positive yet: first data after grace or timeout
          if (cn[p][CNT_W-1] || cn[p] == '0) begin
            fl[p][FLG_NODATA] = 1'b0;
            res.state_changed = 1'b1;
          end
          cn[p] = resp_pos;
        end
      end
      REQ_TICK: begin
        if (cfg.query_en) begin
          if (!cfg.separate && !cfg.single) begin
            res.probe_reserve = fl[0][FLG_ACTIVE] && fl[1][FLG_OPENED];
            res.probe_main    = fl[1][FLG_ACTIVE] && fl[0][FLG_OPENED];
          end
          for (int n = 0; n < 2; n++) begin
            if (cn[n[0]] != '0) begin
              if (cn[n[0]][CNT_W-1]) cn[n[0]] = cn[n[0]] + cnt_t'(1);
              else                   cn[n[0]] = cn[n[0]] - cnt_t'(1);
              if (cn[n[0]] == '0) begin
                fl[n[0]][FLG_NODATA] = 1'b1;
                need = 1'b1;
              end
            end
          end
          if (need) begin
            // main is checked first; only one switchover per tick
            for (int n = 0; n < 2; n++) begin
              if (!swapped && fl[n[0]][FLG_OPENED] && fl[n[0]][FLG_ACTIVE] &&
                  fl[n[0]][FLG_NODATA] && fl[~n[0]][FLG_OPENED]) begin
                swapped = 1'b1;
                if (!cfg.separate) begin
                  fl[n[0]][FLG_ACTIVE]  = 1'b0;
                  fl[~n[0]][FLG_ACTIVE] = 1'b1;
                end
                cn[0] = grace_neg;
                cn[1] = grace_neg;
              end
            end
            res.state_changed = 1'b1;
          end
        end
      end
      default: begin
        fl = flags_i;
      end
    endcase
    res.main_status    = fl[0];
    res.reserve_status = fl[1];
  end

  assign flags_o = fl;
  assign cnt_o   = cn;

endmodule

>>> hdl/redundant_link_failover.sv
// channel  | direction | tdata fields, lowest bit first
// in_      | request   | req_type[1:0], port[2], bad_data[3], zero fill to 8 bits
// out_     | result    | main_status[3:0], reserve_status[7:4], state_changed[8],
//          |           | first_connected[9], all_disconnected[10], probe_main[11],
//          |           | probe_reserve[12], zero fill to 16 bits
// cfg_     | write     | cfg_index selects the register, cfg_wdata[7:0] the value
//
// one request per cycle sustained while out_tready stays high; a request is taken
// into the input register, then its port state update goes into the result register
// synchronous active-low reset clears the link state, the valid flags and the config registers to defaults
// a stalled result holds in the result register while the next request waits in
// the input register; in_tready drops only when both are full

module redundant_link_failover (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [rlf_pkg::IN_TDATA_W-1:0] in_tdata,   // req_type, port, bad_data
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [rlf_pkg::OUT_TDATA_W-1:0] out_tdata, // main_status, reserve_status,
                                                     // state_changed, first_connected,
                                                     // all_disconnected, probe_main,
                                                     // probe_reserve
  input  logic                           cfg_we,
  input  logic [rlf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rlf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rlf_pkg::*;

  cfg_t   cfg;
  logic   in_valid_r;
  req_t   in_req_r;
  logic   out_valid_r;
  res_t   out_res_r;
  flags_t flags_r  [2];
  cnt_t   cnt_r    [2];
  flags_t flags_nxt[2];
  cnt_t   cnt_nxt  [2];
  res_t   res_nxt;
  logic   out_free;
  logic   advance;

  rlf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rlf_step u_step (
    .cfg     (cfg),
    .req     (in_req_r),
    .flags_i (flags_r),
    .cnt_i   (cnt_r),
    .flags_o (flags_nxt),
    .cnt_o   (cnt_nxt),
    .res     (res_nxt)
  );

  assign out_free  = !out_valid_r || out_tready;
  assign advance   = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_req_r.req_type <= req_type_t'(in_tdata[1:0]);
      in_req_r.port     <= in_tdata[2];
      in_req_r.bad_data <= in_tdata[3];
    end
  end

  // port state moves with the request that leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r[0] <= '0;
      flags_r[1] <= '0;
      cnt_r[0]   <= '0;
      cnt_r[1]   <= '0;
    end else if (advance) begin
      flags_r <= flags_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_res_r};

endmodule

>>> hdl/rlf_checker.sv
module rlf_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rlf_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rlf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // an active port is always an open port
  a_active_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[1] && !out_tdata[0]) && !(out_tdata[5] && !out_tdata[4]))
    else $error("active flag on a closed port");

  // after the last port goes down neither port is open
  a_alldown: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> !out_tdata[0] && !out_tdata[4] && out_tdata[8])
    else $error("all_disconnected with a port still open");

  // a first connect leaves exactly one port open
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[9] |-> (out_tdata[0] ^ out_tdata[4]) && !out_tdata[10])
    else $error("first_connected with wrong open state");

endmodule

bind redundant_link_failover rlf_checker u_rlf_checker (.*);
